// ===== rtl/newreno_congestion_control_macros.svh =====
// Assertion macros for the NewReno window engine
`ifndef NEWRENO_CONGESTION_CONTROL_MACROS_SVH
`define NEWRENO_CONGESTION_CONTROL_MACROS_SVH
// implication checked at every rising clock edge outside reset
`define NR_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// next-cycle implication
`define NR_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// ===== rtl/nrcc_pkg.sv =====
// Package: types and constants of the NewReno window engine
package nrcc_pkg;
  localparam int QW = 24;
  localparam int SW = 9;
  localparam int MAX_SEGS = 256;  // send-time store depth, bounded by the 9-bit sequence
  localparam logic [QW-1:0] QMAX = 24'hFFFFFF;
  localparam logic [7:0] DUP_TRIGGER = 8'd3;

  typedef enum logic [1:0] {OP_START = 2'd0, OP_ACK = 2'd1, OP_SEND = 2'd2,
                            OP_TIMER = 2'd3} op_e;
  typedef enum logic [1:0] {PH_SS = 2'd0, PH_CA = 2'd1, PH_FR = 2'd2} phase_e;
  typedef enum logic [1:0] {K_NONE = 2'd0, K_NEW = 2'd1, K_FAST = 2'd2,
                            K_TMO = 2'd3} kind_e;
  typedef enum logic [1:0] {REG_TOTAL = 2'd0, REG_SSTH = 2'd1, REG_RTO = 2'd2} reg_e;
  typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_TREAD, ST_SEND, ST_OUT} state_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [8:0]  ack_number;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [8:0]  sequence_res;
    logic [23:0] window;
    logic [23:0] threshold;
    logic [1:0]  phase;
    logic        last;
    logic        finished;
  } out_item_t;

  // control from the engine to the time store
  typedef struct packed {
    logic        we;
    logic        re;
  } tstore_ctl_t;
endpackage

// ===== rtl/nrcc_time_store.sv =====
// Send-time store: one write port, one registered read port
module nrcc_time_store #(
  parameter int MAX_SEGS = 256
) (
  input  logic                        clk_i,
  input  nrcc_pkg::tstore_ctl_t       ctl_i,
  input  logic [$clog2(MAX_SEGS)-1:0] waddr_i,
  input  logic [31:0]                 wdata_i,
  input  logic [$clog2(MAX_SEGS)-1:0] raddr_i,
  output logic [31:0]                 rdata_o
);
  import nrcc_pkg::*;
  logic [31:0] mem [MAX_SEGS];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) mem[waddr_i] <= wdata_i;
    if (ctl_i.re) rdata_q <= mem[raddr_i];
  end
  assign rdata_o = rdata_q;
endmodule

// ===== rtl/nrcc_divider.sv =====
// Radix-2 restoring divider for the avoidance increment
module nrcc_divider #(
  parameter int NW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [23:0]   den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);
  import nrcc_pkg::*;
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] quo_q, quo_d;
  logic [24:0]   rem_q, rem_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic [23:0]   den_q;
  logic [25:0]   trial;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; cnt_d = cnt_q; busy_d = busy_q;
    trial = '0;
    if (start_i) begin
      quo_d = num_i; rem_d = '0; cnt_d = CW'(NW); busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, quo_q[NW-1]} - {2'b0, den_q};
      if (!trial[25]) rem_d = trial[24:0];
      else rem_d = {rem_q[23:0], quo_q[NW-1]};
      quo_d = {quo_q[NW-2:0], ~trial[25]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d;
    if (start_i) den_q <= (den_i == '0) ? 24'd1 : den_i;
  end
  assign done_o = busy_q && (cnt_q == CW'(1));
  assign quo_o  = quo_d;
endmodule

// ===== rtl/newreno_congestion_control.sv =====
// Top level of the NewReno sender window engine
//  channel | dir | handshake          | payload
//  in      | in  | in_valid_i/ready_o | nrcc_pkg::in_item_t
//  out     | out | out_valid_o/ready_i| nrcc_pkg::out_item_t
//  cfg     | in  | APB psel/penable   | 32-bit registers at 0x0, 0x4, 0x8
// Flow: start goes through ST_OUT, timer check through ST_TREAD, duplicate,
// slow start and fast recovery ACKs through ST_DIV to a result (the send-time
// read overlaps the accepting cycle); avoidance ACKs latch the acked count,
// then start the divider, which gives one quotient bit a cycle. A send
// opportunity gives one new segment per cycle while out is not stalled.
// Reset clears control state; the send-time store is not cleared.
// Stalls: a result waits in the output register; input is held off meanwhile.
module newreno_congestion_control #(
  parameter int FRAC_BITS = 8,
  parameter int MAX_BURST = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  nrcc_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output nrcc_pkg::out_item_t  out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import nrcc_pkg::*;
  localparam int AW = $clog2(MAX_SEGS);
  localparam int NW = 1 + 2 * FRAC_BITS + SW; // numerator bits
  localparam int BW = $clog2(MAX_BURST + 1);
  localparam logic [QW-1:0] QONE = QW'(1) << FRAC_BITS;
  localparam logic [SW-1:0] SEG_MAX = (MAX_SEGS - 1 > 511) ? SW'(511) : SW'(MAX_SEGS - 1);

  // configuration registers
  logic [7:0]  total_q;
  logic [7:0]  ssth_q;
  logic [15:0] rto_q;
  logic        cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= 8'd255; ssth_q <= 8'd16; rto_q <= 16'd800;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_TOTAL: total_q <= pwdata[7:0];
        REG_SSTH:  ssth_q  <= pwdata[7:0];
        REG_RTO:   rto_q   <= pwdata[15:0];
        default:   ;
      endcase
    end
  end
  always_comb begin
    case (paddr[3:2])
      REG_TOTAL: prdata = {24'd0, total_q};
      REG_SSTH:  prdata = {24'd0, ssth_q};
      REG_RTO:   prdata = {16'd0, rto_q};
      default:   prdata = '0;
    endcase
  end

  // engine state
  state_e         st_q, st_d;
  logic [SW-1:0]  una_q, una_d, nxt_q, nxt_d, rec_q, rec_d, lim_q, lim_d;
  logic [QW-1:0]  cw_q, cw_d, ss_q, ss_d;
  phase_e         ph_q, ph_d;
  logic [7:0]     dup_q, dup_d;
  logic           run_q, run_d;
  in_item_t       it_q, it_d;
  logic [SW-1:0]  newly_q, newly_d;
  logic [BW-1:0]  n_q, n_d;
  logic [SW-1:0]  win_q, win_d;
  out_item_t      o_q, o_d;
  logic           ov_q, ov_d;

  logic           dstart, ddone;
  logic [NW-1:0]  dquo;
  tstore_ctl_t    tctl;
  logic [31:0]    trd;

  nrcc_divider #(.NW(NW)) u_div (
    .clk_i, .rst_ni, .start_i(dstart),
    .num_i(NW'(newly_q) << (2 * FRAC_BITS)), .den_i(cw_q),
    .done_o(ddone), .quo_o(dquo)
  );
  nrcc_time_store #(.MAX_SEGS(MAX_SEGS)) u_ts (
    .clk_i, .ctl_i(tctl), .waddr_i(nxt_q[AW-1:0]), .wdata_i(it_q.now_ms),
    .raddr_i(una_q[AW-1:0]), .rdata_o(trd)
  );

  function automatic logic [QW-1:0] satadd(input logic [QW-1:0] a,
                                           input logic [QW:0] b);
    logic [QW+1:0] s;
    s = {2'b0, a} + {1'b0, b};
    return (s > {2'b0, QMAX}) ? QMAX : s[QW-1:0];
  endfunction

  logic [QW-1:0] half2;
  logic [SW-1:0] ackc;
  logic [QW+SW:0] dec;
  logic [QW-1:0]  cwin;
  logic [SW-1:0]  lat;
  logic [31:0]    age;
  logic [QW-1:0]  ssl;

  always_comb begin
    half2 = ((cw_q >> 1) < (QONE << 1)) ? (QONE << 1) : (cw_q >> 1);
    ackc  = (it_q.ack_number > nxt_q) ? nxt_q : it_q.ack_number;
    dec   = (QW+SW+1)'(ackc - una_q - 1'b1) << FRAC_BITS;
    cwin  = cw_q >> FRAC_BITS;
    lat   = (total_q == 8'd0) ? SW'(1) : ((SW'(total_q) > SEG_MAX) ? SEG_MAX : SW'(total_q));
    age   = it_q.now_ms - trd;
    ssl   = ((QW + 8)'(ssth_q) << FRAC_BITS) > (QW + 8)'(QMAX) ? QMAX
            : QW'((QW + 8)'(ssth_q) << FRAC_BITS);
  end

  // result built from next-state values
  function automatic out_item_t mk(input logic [1:0] k, input logic [SW-1:0] s,
      input logic [QW-1:0] cw, input logic [QW-1:0] ss, input phase_e ph,
      input logic lst, input logic rn, input logic [SW-1:0] un,
      input logic [SW-1:0] lm);
    out_item_t r;
    r.kind = k; r.sequence_res = s; r.window = cw; r.threshold = ss;
    r.phase = ph; r.last = lst; r.finished = rn && (un > lm);
    return r;
  endfunction

  logic send_more;
  always_comb begin
    st_d = st_q; una_d = una_q; nxt_d = nxt_q; rec_d = rec_q; lim_d = lim_q;
    cw_d = cw_q; ss_d = ss_q; ph_d = ph_q; dup_d = dup_q; run_d = run_q;
    it_d = it_q; newly_d = newly_q; n_d = n_q; win_d = win_q;
    o_d = o_q; ov_d = ov_q;
    dstart = 1'b0; tctl = '0;
    in_ready_o = (st_q == ST_IDLE) && !ov_q;
    send_more = (n_q < BW'(MAX_BURST)) && (nxt_q <= lim_q) && ((nxt_q - una_q) < win_q);
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (st_q)
      ST_IDLE: if (in_valid_i && in_ready_o) begin
        it_d = in_data_i; st_d = ST_OUT;
        n_d = '0;
        win_d = (cwin == '0) ? SW'(1) : ((cwin > QW'(511)) ? SW'(511) : SW'(cwin));
        if (in_data_i.operation == OP_START) begin
          run_d = 1'b1; lim_d = lat; una_d = SW'(1); nxt_d = SW'(1);
          cw_d = QONE; ss_d = ssl; ph_d = PH_SS; dup_d = '0; rec_d = '0;
        end else if (run_q && in_data_i.operation == OP_SEND) st_d = ST_SEND;
        else if (run_q && in_data_i.operation == OP_TIMER) begin
          tctl.re = 1'b1; st_d = ST_TREAD;
        end
        else if (run_q && in_data_i.operation == OP_ACK) st_d = ST_DIV;
      end
      ST_DIV: begin
        // ACK handling; avoidance waits for the divider
        o_d = mk(K_NONE, '0, cw_q, ss_q, ph_q, 1'b1, run_q, una_q, lim_q);
        if (ackc <= una_q) begin
          dup_d = (dup_q == 8'd255) ? dup_q : dup_q + 8'd1;
          if (ph_q != PH_FR && dup_d == DUP_TRIGGER) begin
            ss_d = half2; cw_d = satadd(half2, (QW+1)'(QONE) * (QW+1)'(3));
            rec_d = nxt_q - 1'b1; ph_d = PH_FR;
            o_d = mk(K_FAST, una_q, cw_d, ss_d, PH_FR, 1'b1, run_q, una_q, lim_q);
          end else if (ph_q == PH_FR) begin
            cw_d = satadd(cw_q, (QW+1)'(QONE));
            o_d.window = cw_d;
          end else o_d.kind = K_NONE;
          ov_d = 1'b1; st_d = ST_IDLE;
        end else if (ph_q == PH_CA && newly_q == '0 && n_q == '0) begin
          newly_d = ackc - una_q; n_d = BW'(1);
        end else if (ph_q == PH_CA && n_q == BW'(1)) begin
          dstart = 1'b1; n_d = BW'(2);
        end else if (ph_q == PH_CA && n_q == BW'(2)) begin
          if (ddone) begin
            cw_d = (dquo > NW'(QMAX)) ? QMAX : satadd(cw_q, (QW+1)'(dquo));
            una_d = ackc; dup_d = '0; newly_d = '0;
            o_d = mk(K_NONE, '0, cw_d, ss_q, ph_q, 1'b1, run_q, ackc, lim_q);
            ov_d = 1'b1; st_d = ST_IDLE;
          end
        end else begin
          una_d = ackc; dup_d = '0;
          if (ph_q == PH_FR) begin
            if (ackc > rec_q) begin
              cw_d = ss_q; ph_d = PH_CA;
              o_d = mk(K_NONE, '0, cw_d, ss_q, PH_CA, 1'b1, run_q, ackc, lim_q);
            end else begin
              cw_d = (dec >= (QW+SW+1)'(cw_q)) ? QONE
                     : (((cw_q - QW'(dec)) < QONE) ? QONE : cw_q - QW'(dec));
              o_d = mk(K_FAST, ackc, cw_d, ss_q, ph_q, 1'b1, run_q, ackc, lim_q);
            end
          end else begin
            cw_d = satadd(cw_q, (QW+1)'(ackc - una_q) << FRAC_BITS);
            if (cw_d >= ss_q) ph_d = PH_CA;
            o_d = mk(K_NONE, '0, cw_d, ss_q, ph_d, 1'b1, run_q, ackc, lim_q);
          end
          ov_d = 1'b1; st_d = ST_IDLE;
        end
      end
      ST_TREAD: begin
        o_d = mk(K_NONE, '0, cw_q, ss_q, ph_q, 1'b1, run_q, una_q, lim_q);
        if (una_q <= lim_q && nxt_q != una_q && age >= {16'd0, rto_q}) begin
          ss_d = half2; cw_d = QONE; ph_d = PH_SS; dup_d = '0; nxt_d = una_q;
          o_d = mk(K_TMO, una_q, QONE, half2, PH_SS, 1'b1, run_q, una_q, lim_q);
        end
        ov_d = 1'b1; st_d = ST_IDLE;
      end
      ST_SEND: if (!ov_q || out_ready_i) begin
        if (send_more) begin
          tctl.we = 1'b1; nxt_d = nxt_q + 1'b1; n_d = n_q + 1'b1;
          o_d = mk(K_NEW, nxt_q, cw_q, ss_q, ph_q, 1'b0, run_q, una_q, lim_q);
          o_d.last = !((n_d < BW'(MAX_BURST)) && (nxt_d <= lim_q) && ((nxt_d - una_q) < win_q));
          ov_d = 1'b1;
          if (o_d.last) st_d = ST_IDLE;
        end else begin
          o_d = mk(K_NONE, '0, cw_q, ss_q, ph_q, 1'b1, run_q, una_q, lim_q);
          ov_d = 1'b1; st_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        o_d = mk(K_NONE, '0, cw_q, ss_q, ph_q, 1'b1, run_q, una_q, lim_q);
        ov_d = 1'b1; st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; una_q <= SW'(1); nxt_q <= SW'(1); rec_q <= '0;
      lim_q <= SEG_MAX > SW'(255) ? SW'(255) : SEG_MAX;
      cw_q <= QONE; ss_q <= QW'(16) << FRAC_BITS; ph_q <= PH_SS; dup_q <= '0;
      run_q <= 1'b0; ov_q <= 1'b0; n_q <= '0; newly_q <= '0;
    end else begin
      st_q <= st_d; una_q <= una_d; nxt_q <= nxt_d; rec_q <= rec_d; lim_q <= lim_d;
      cw_q <= cw_d; ss_q <= ss_d; ph_q <= ph_d; dup_q <= dup_d; run_q <= run_d;
      ov_q <= ov_d; n_q <= n_d; newly_q <= newly_d;
    end
  end
  always_ff @(posedge clk_i) begin
    it_q <= it_d; win_q <= win_d; o_q <= o_d;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = o_q;
endmodule

// ===== rtl/nrcc_checker.sv =====
// Port-level checker for the NewReno window engine, bound to the top level
`include "newreno_congestion_control_macros.svh"
module nrcc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input nrcc_pkg::out_item_t out_data_o
);
  import nrcc_pkg::*;
  `NR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                 out_valid_o && $stable(out_data_o))
  `NR_ASSERT_IMP(a_no_take_while_full, clk_i, rst_ni, out_valid_o, !in_ready_o)
  `NR_ASSERT_IMP(a_phase_range, clk_i, rst_ni, out_valid_o,
                 out_data_o.phase != 2'd3)
  `NR_ASSERT_IMP(a_none_is_zero, clk_i, rst_ni,
                 out_valid_o && out_data_o.kind == K_NONE,
                 out_data_o.sequence_res == '0 && out_data_o.last)
endmodule

bind newreno_congestion_control nrcc_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the NewReno sender window engine
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import nrcc_pkg::*;

  localparam int          SEG_TOP    = 255;      // highest usable sequence (MAX_SEGS-1)
  localparam int unsigned ONE_SEG    = 256;      // 1.0 in Q16.8
  localparam int          BURST_CAP  = 64;
  localparam int          DRAIN_WAIT = 40;       // covers a full divider run
  localparam int          CYCLE_CAP  = 1000000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;
  logic      psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  newreno_congestion_control dut (.*);

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Window predictor: own copy of sender state and register shadows
  // ---------------------------------------------------------------------------
  int unsigned reg_total = 255, reg_ssth = 16, reg_rto = 800;
  int unsigned snd_una, snd_nxt, cwnd, ssthresh, dupacks, recover, seg_last;
  phase_e      cc_phase;
  bit          active;
  int unsigned sent_at [256];

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int        items_queued, items_taken, errors, cycles;
  bit        calm;   // phase with no idling on either side
  logic [31:0] clock_ms;

  function automatic int unsigned q_sat(longint unsigned v);
    return (v > 64'hFFFFFF) ? 32'hFFFFFF : int'(v);
  endfunction

  function automatic int unsigned half_window();
    int unsigned h;
    h = cwnd >> 1;
    return (h < 2 * ONE_SEG) ? 2 * ONE_SEG : h;
  endfunction

  function automatic void push_result(kind_e k, int unsigned sq);
    out_item_t r;
    r.kind         = k;
    r.sequence_res = sq[8:0];
    r.window       = cwnd[23:0];
    r.threshold    = ssthresh[23:0];
    r.phase        = cc_phase;
    r.last         = 1'b0;
    r.finished     = active && snd_una > seg_last;
    expected_results.push_back(r);
  endfunction

  // ACK handling: duplicates, fast retransmit, partial/full ACK, growth
  function automatic void take_ack(int unsigned ackn, ref kind_e k, ref int unsigned sq);
    int unsigned newly;
    longint unsigned dec, cw, dv;
    if (ackn > snd_nxt) ackn = snd_nxt;
    if (ackn <= snd_una) begin
      if (dupacks < 255) dupacks++;
      if (cc_phase != PH_FR && dupacks == 3) begin
        ssthresh = half_window();
        cwnd     = q_sat(longint'(ssthresh) + 3 * ONE_SEG);
        recover  = (snd_nxt - 1) & 9'h1FF;
        cc_phase = PH_FR;
        k  = K_FAST;
        sq = snd_una;
      end else if (cc_phase == PH_FR) begin
        cwnd = q_sat(longint'(cwnd) + ONE_SEG);
      end
      return;
    end
    newly   = ackn - snd_una;
    snd_una = ackn;
    dupacks = 0;
    if (cc_phase == PH_FR) begin
      if (ackn > recover) begin
        cwnd     = ssthresh;
        cc_phase = PH_CA;
      end else begin
        dec  = longint'(newly - 1) << 8;
        cw   = cwnd;
        cw   = (dec >= cw) ? 0 : cw - dec;
        if (cw < ONE_SEG) cw = ONE_SEG;
        cwnd = q_sat(cw);
        k  = K_FAST;
        sq = ackn;
      end
    end else if (cc_phase == PH_SS) begin
      cwnd = q_sat(longint'(cwnd) + (longint'(newly) << 8));
      if (cwnd >= ssthresh) cc_phase = PH_CA;
    end else begin
      dv   = (cwnd != 0) ? cwnd : 1;
      cwnd = q_sat(longint'(cwnd) + ((longint'(newly) << 16) / dv));
    end
  endfunction

  function automatic void predict_item(in_item_t it);
    kind_e       k;
    int unsigned sq, win, age;
    int          n, first;
    k = K_NONE; sq = 0; n = 0;
    first = expected_results.size();
    if (it.operation == OP_START) begin
      active   = 1;
      seg_last = (reg_total < 1) ? 1 : ((reg_total > SEG_TOP) ? SEG_TOP : reg_total);
      snd_una  = 1; snd_nxt = 1;
      cwnd     = ONE_SEG;
      ssthresh = q_sat(longint'(reg_ssth) << 8);
      cc_phase = PH_SS; dupacks = 0; recover = 0;
    end else if (active && it.operation == OP_ACK) begin
      take_ack(it.ack_number, k, sq);
    end else if (active && it.operation == OP_SEND) begin
      win = cwnd >> 8;
      if (win < 1) win = 1;
      // a burst leaves window, threshold and phase untouched
      while (n < BURST_CAP && snd_nxt <= seg_last && snd_nxt - snd_una < win) begin
        sent_at[snd_nxt] = it.now_ms;
        snd_nxt++;
        push_result(K_NEW, snd_nxt - 1);
        n++;
      end
    end else if (active && it.operation == OP_TIMER) begin
      if (snd_una <= seg_last && snd_nxt != snd_una) begin
        age = it.now_ms - sent_at[snd_una];   // wraps modulo 2^32
        if (age >= reg_rto) begin
          ssthresh = half_window();
          cwnd     = ONE_SEG;
          cc_phase = PH_SS;
          dupacks  = 0;
          snd_nxt  = snd_una;
          k  = K_TMO;
          sq = snd_una;
        end
      end
    end
    if (n == 0) push_result(k, sq);
    expected_results[expected_results.size() - 1].last = 1'b1;
    pending_items.push_back(it);
    items_queued++;
  endfunction

  function automatic void queue_op(op_e op, int unsigned ackn, logic [31:0] now);
    in_item_t it;
    it.operation  = op;
    it.ack_number = ackn[8:0];
    it.now_ms     = now;
    predict_item(it);
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 9);
    if (r < 5) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // random traffic: mostly a well-formed transfer, some noise
  function automatic void queue_random(int count);
    int r, s;
    int unsigned a, span;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 3 || (active && snd_una > seg_last && r < 40)) begin
        queue_op(OP_START, $urandom_range(0, 256), $urandom);
      end else if (r < 42) begin
        s = $urandom_range(0, 9);
        span = (snd_nxt > snd_una) ? snd_nxt - snd_una : 1;
        if (s < 3)       a = snd_una;
        else if (s == 3) a = $urandom_range(0, 256);
        else             a = snd_una + $urandom_range(1, span);
        queue_op(OP_ACK, a, $urandom);
      end else if (r < 75) begin
        clock_ms += $urandom_range(0, 50);
        queue_op(OP_SEND, $urandom_range(0, 256),
                 ($urandom_range(0, 19) == 0) ? $urandom : clock_ms);
      end else begin
        if ($urandom_range(0, 3) == 0) clock_ms += reg_rto + $urandom_range(0, 100);
        else                           clock_ms += $urandom_range(0, reg_rto);
        queue_op(OP_TIMER, $urandom_range(0, 256), clock_ms);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: changes at the falling edge, holds until the transfer
  // ---------------------------------------------------------------------------
  bit in_taken;
  int in_gap;
  bit stim_on;

  always @(negedge clk_i) begin
    if (in_valid_i && !in_taken) begin
      // hold item until it is taken
    end else if (in_gap > 0) begin
      in_valid_i <= 1'b0;
      in_gap--;
    end else if (stim_on && pending_items.size() > 0) begin
      in_data_i  <= pending_items.pop_front();
      in_valid_i <= 1'b1;
      in_gap     = idle_len();
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // output back-pressure
  int out_stall;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (out_stall > 0) begin
      out_ready_i <= 1'b0;
      out_stall--;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_stall = idle_len();
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples at the rising edge, checks each result transfer in order
  // ---------------------------------------------------------------------------
  task automatic report(string what, out_item_t got, out_item_t want);
    errors++;
    $display("mismatch %s: got %p want %p", what, got, want);
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    in_taken = in_valid_i && in_ready_o;
    if (in_taken) items_taken++;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report("unexpected result", out_data_o, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.kind !== want.kind)                 report("kind", out_data_o, want);
        if (out_data_o.sequence_res !== want.sequence_res) report("sequence", out_data_o, want);
        if (out_data_o.window !== want.window)             report("window", out_data_o, want);
        if (out_data_o.threshold !== want.threshold)       report("threshold", out_data_o, want);
        if (out_data_o.phase !== want.phase)               report("phase", out_data_o, want);
        if (out_data_o.last !== want.last)                 report("last", out_data_o, want);
        if (out_data_o.finished !== want.finished)         report("finished", out_data_o, want);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // APB register write: setup then access cycle, only while idle
  // ---------------------------------------------------------------------------
  task automatic reg_write(reg_e idx, int unsigned val);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 4'(idx * 4); pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_TOTAL: reg_total = val & 8'hFF;
      REG_SSTH:  reg_ssth  = val & 8'hFF;
      default:   reg_rto   = val & 16'hFFFF;
    endcase
  endtask

  task automatic drain();
    stim_on = 1;
    wait (items_taken == items_queued && expected_results.size() == 0);
    stim_on = 0;
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic setup(int unsigned tot, int unsigned th, int unsigned rto, bit quiet);
    reg_write(REG_TOTAL, tot);
    reg_write(REG_SSTH, th);
    reg_write(REG_RTO, rto);
    calm = quiet;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of phases
  // ---------------------------------------------------------------------------
  initial begin
    snd_una = 1; snd_nxt = 1; cwnd = ONE_SEG; ssthresh = 16 * ONE_SEG;
    cc_phase = PH_SS; seg_last = 255; active = 0;
    clock_ms = 32'hFFFF_FF00;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: idle engine, start, growth, fast recovery, timeout across a wrap
    queue_op(OP_ACK, 256, 0);
    queue_op(OP_SEND, 0, 32'hFFFF_FFFF);
    queue_op(OP_TIMER, 0, 32'hFFFF_FFFF);
    queue_op(OP_START, 511, 32'hFFFF_FFFF);
    queue_op(OP_SEND, 0, 32'hFFFF_FF00);
    queue_op(OP_ACK, 2, 0);
    queue_op(OP_SEND, 0, 32'hFFFF_FF10);
    queue_op(OP_ACK, 3, 0);
    queue_op(OP_ACK, 4, 0);
    queue_op(OP_SEND, 0, 32'hFFFF_FF20);
    repeat (4) queue_op(OP_ACK, 4, 0);       // three duplicates, then inflation
    queue_op(OP_ACK, 5, 0);                   // partial ACK
    queue_op(OP_ACK, 256, 0);                 // beyond send point, full ACK
    queue_op(OP_SEND, 0, 32'hFFFF_FF40);
    queue_op(OP_TIMER, 0, 32'h0000_0100);     // wrapped age below the timeout
    queue_op(OP_TIMER, 0, 32'h0000_1000);     // timeout
    queue_op(OP_ACK, 0, 0);
    queue_op(OP_SEND, 0, 32'h0000_1000);
    clock_ms = 32'h0000_1000;
    calm = 0;
    drain();

    queue_random(20);
    drain();
    setup(10, 2, 1, 1);
    queue_op(OP_START, 0, 0);
    queue_random(15);
    drain();
    setup(1, 255, 65535, 0);
    queue_op(OP_START, 0, 0);
    queue_random(10);
    drain();
    setup(0, 0, 0, 0);                         // out-of-range total and threshold
    queue_op(OP_START, 0, 0);
    queue_random(10);
    drain();
    setup($urandom_range(20, 255), $urandom_range(2, 64), $urandom_range(30, 400), 0);
    queue_op(OP_START, 0, 0);
    queue_random(20);
    drain();

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
